/* hw/rtl/shbe_pkg.sv */
`default_nettype none

package shbe_pkg;

  localparam int NUM_LANES = 16;
  localparam int LANE_W    = 64;
  localparam int LANE_AW   = 4;
  localparam int POS_W     = 7;
  localparam int RND_W     = 6;
  localparam int AMT_W     = 6;

  localparam int DEF_ROUNDS     = 24;
  localparam int DEF_RATE_BYTES = 32;

  localparam int CQ_DEPTH = 4;
  localparam int OQ_DEPTH = 2;

  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_ABSORB  = 2'd1;
  localparam logic [1:0] KIND_FINISH  = 2'd2;
  localparam logic [1:0] KIND_SQUEEZE = 2'd3;

  localparam logic [7:0] PAD_START = 8'h1F;
  localparam logic [7:0] PAD_END   = 8'h80;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cq_wr_t;

  typedef struct packed {
    logic       push;
    logic [7:0] data;
  } oq_wr_t;

  function automatic logic [LANE_W-1:0] rotl(input logic [LANE_W-1:0] x,
                                             input logic [AMT_W-1:0]  amt);
    logic [2*LANE_W-1:0] t;
    t = {x, x} << amt;
    return t[2*LANE_W-1:LANE_W];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/shbe_fifo.sv */
`default_nettype none

// depth must be a power of two
module shbe_fifo #(
  parameter int W     = shbe_pkg::CMD_W,
  parameter int DEPTH = shbe_pkg::CQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + AW'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/shbe_front.sv */
`default_nettype none

module shbe_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      in_kind,
  input  logic [7:0]      in_data_byte,
  input  logic            cq_full,
  output shbe_pkg::cq_wr_t cq_wr
);

  import shbe_pkg::*;

  logic sq_r, sq_nxt;
  logic accept;
  logic drop;

  assign full   = cq_full;
  assign accept = push & ~cq_full;
  // absorb and finish have no effect once squeezing
  assign drop   = sq_r & ((in_kind == KIND_ABSORB) || (in_kind == KIND_FINISH));

  always_comb begin
    cq_wr.push     = accept & ~drop;
    cq_wr.cmd.kind = in_kind;
    cq_wr.cmd.data = in_data_byte;
  end

  always_comb begin
    sq_nxt = sq_r;
    if (accept) begin
      unique case (in_kind)
        KIND_CLEAR:   sq_nxt = 1'b0;
        KIND_ABSORB:  sq_nxt = sq_r;
        KIND_FINISH:  sq_nxt = 1'b1;
        KIND_SQUEEZE: sq_nxt = sq_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r <= 1'b0;
    end else begin
      sq_r <= sq_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/shbe_back.sv */
`default_nettype none

module shbe_back #(
  parameter int ROUNDS     = shbe_pkg::DEF_ROUNDS,
  parameter int RATE_BYTES = shbe_pkg::DEF_RATE_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  shbe_pkg::cmd_t   cq_cmd,
  input  logic             cq_empty,
  output logic             cq_pop,
  input  logic             oq_full,
  output shbe_pkg::oq_wr_t oq_wr
);

  import shbe_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RMW    = 3'd1;
  localparam logic [2:0] ST_PAD_RD = 3'd2;
  localparam logic [2:0] ST_PAD_WR = 3'd3;
  localparam logic [2:0] ST_SQZ    = 3'd4;
  localparam logic [2:0] ST_P_RD   = 3'd5;
  localparam logic [2:0] ST_P_MIX  = 3'd6;
  localparam logic [2:0] ST_P_WR   = 3'd7;

  localparam logic [POS_W-1:0]   RATE_POS  = POS_W'(RATE_BYTES);
  localparam logic [POS_W-1:0]   LAST_POS  = POS_W'(RATE_BYTES - 1);
  localparam logic [LANE_AW-1:0] LAST_LANE = {1'b0, LAST_POS[5:3]};
  localparam logic [AMT_W-1:0]   LAST_SH   = {LAST_POS[2:0], 3'b000};
  localparam logic [RND_W-1:0]   LAST_RND  = RND_W'(ROUNDS - 1);
  localparam logic [LANE_AW-1:0] LAST_UPD  = LANE_AW'(NUM_LANES - 1);

  logic [2:0]         state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [RND_W-1:0]   rnd_r, rnd_nxt;
  logic [LANE_AW-1:0] upd_r, upd_nxt;
  logic [LANE_W-1:0]  mix_r, mix_nxt;

  logic [LANE_W-1:0]  lane_mem [NUM_LANES];
  logic [NUM_LANES-1:0] lane_vld_r;
  logic [LANE_W-1:0]  rda_r, rdb_r;
  logic               rda_vld_r, rdb_vld_r;

  logic [LANE_AW-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic               wr_en, clr_all;
  logic [LANE_W-1:0]  wr_data;

  logic [LANE_W-1:0]  a_val, b_val;
  logic [LANE_AW-1:0] pos_lane, pa, pb, dst;
  logic [AMT_W-1:0]   pos_sh, amt_a, amt_b;

  // a lane not written since the last clear reads as zero
  assign a_val    = rda_vld_r ? rda_r : '0;
  assign b_val    = rdb_vld_r ? rdb_r : '0;
  assign pos_lane = {1'b0, pos_r[5:3]};
  assign pos_sh   = {pos_r[2:0], 3'b000};
  assign pa       = rnd_r[LANE_AW-1:0] + upd_r;
  assign pb       = pa + LANE_AW'(1);
  assign dst      = LAST_UPD - upd_r;
  assign amt_a    = rnd_r + AMT_W'(upd_r[3:1]) + AMT_W'(1);
  assign amt_b    = rnd_r + AMT_W'({upd_r, 1'b0}) + AMT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    rnd_nxt    = rnd_r;
    upd_nxt    = upd_r;
    mix_nxt    = mix_r;
    cq_pop     = 1'b0;
    oq_wr.push = 1'b0;
    oq_wr.data = 8'(a_val >> pos_sh);
    rd_a_addr  = pos_lane;
    rd_b_addr  = pb;
    wr_en      = 1'b0;
    wr_addr    = pos_lane;
    wr_data    = a_val ^ (LANE_W'(cq_cmd.data) << pos_sh);
    clr_all    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!cq_empty) begin
          // a full rate is permuted lazily, ahead of the next command that needs it
          priority if (cq_cmd.kind == KIND_CLEAR) begin
            clr_all = 1'b1;
            pos_nxt = '0;
            cq_pop  = 1'b1;
          end else if (pos_r >= RATE_POS) begin
            rnd_nxt   = '0;
            upd_nxt   = '0;
            state_nxt = ST_P_RD;
          end else if (cq_cmd.kind == KIND_SQUEEZE) begin
            if (!oq_full) begin
              state_nxt = ST_SQZ;
            end
          end else begin
            state_nxt = ST_RMW;
          end
        end
      end
      ST_RMW: begin
        wr_en = 1'b1;
        if (cq_cmd.kind == KIND_ABSORB) begin
          pos_nxt   = pos_r + POS_W'(1);
          cq_pop    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          wr_data   = a_val ^ (LANE_W'(PAD_START) << pos_sh);
          state_nxt = ST_PAD_RD;
        end
      end
      ST_PAD_RD: begin
        rd_a_addr = LAST_LANE;
        state_nxt = ST_PAD_WR;
      end
      ST_PAD_WR: begin
        wr_en     = 1'b1;
        wr_addr   = LAST_LANE;
        wr_data   = a_val ^ (LANE_W'(PAD_END) << LAST_SH);
        pos_nxt   = RATE_POS;
        cq_pop    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SQZ: begin
        oq_wr.push = 1'b1;
        pos_nxt    = pos_r + POS_W'(1);
        cq_pop     = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_P_RD: begin
        rd_a_addr = pa;
        rd_b_addr = pb;
        state_nxt = ST_P_MIX;
      end
      ST_P_MIX: begin
        mix_nxt   = rotl(a_val, amt_a) ^ rotl(b_val, amt_b) ^ LANE_W'(1);
        rd_a_addr = dst;
        state_nxt = ST_P_WR;
      end
      ST_P_WR: begin
        wr_en     = 1'b1;
        wr_addr   = dst;
        wr_data   = a_val ^ mix_r;
        upd_nxt   = upd_r + LANE_AW'(1);
        state_nxt = ST_P_RD;
        if (upd_r == LAST_UPD) begin
          if (rnd_r == LAST_RND) begin
            pos_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            rnd_nxt = rnd_r + RND_W'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      rnd_r   <= '0;
      upd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      upd_r   <= upd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mix_r <= mix_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lane_mem[wr_addr] <= wr_data;
    end
    rda_r     <= lane_mem[rd_a_addr];
    rdb_r     <= lane_mem[rd_b_addr];
    rda_vld_r <= lane_vld_r[rd_a_addr];
    rdb_vld_r <= lane_vld_r[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_vld_r <= '0;
    end else if (clr_all) begin
      lane_vld_r <= '0;
    end else if (wr_en) begin
      lane_vld_r[wr_addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sponge_hash_byte_engine.sv */
// Byte-serial sponge hash over sixteen 64-bit lanes, queue-style on both sides:
// commands go in with push/full, squeezed bytes come out with empty/pop. A front
// stage tracks absorb/squeeze mode and discards absorb and finish commands while
// squeezing; the rest wait in a four-entry command queue for the back end, which
// keeps the lanes in a 16 x 64 memory with two registered read ports and one
// write port. Once the rate is used up the next absorb, finish or squeeze
// first runs the permutation: each lane update is a read, mix and write on the
// lane memory, done for every lane in each round. Results queue in a two-entry
// output queue, so a squeeze stalls only when both entries are waiting.
`default_nettype none

module sponge_hash_byte_engine #(
  parameter int ROUNDS     = shbe_pkg::DEF_ROUNDS,
  parameter int RATE_BYTES = shbe_pkg::DEF_RATE_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte
);

  import shbe_pkg::*;

  cq_wr_t           cq_wr;
  logic [CMD_W-1:0] cq_rd_data;
  cmd_t             cq_cmd;
  logic             cq_full, cq_empty, cq_pop;
  oq_wr_t           oq_wr;
  logic             oq_full;

  assign cq_cmd = cmd_t'(cq_rd_data);

  shbe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .cq_full      (cq_full),
    .cq_wr        (cq_wr)
  );

  shbe_fifo #(
    .W     (CMD_W),
    .DEPTH (CQ_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cq_wr.push),
    .wr_data (cq_wr.cmd),
    .full    (cq_full),
    .rd_en   (cq_pop),
    .rd_data (cq_rd_data),
    .empty   (cq_empty)
  );

  shbe_back #(
    .ROUNDS     (ROUNDS),
    .RATE_BYTES (RATE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_cmd   (cq_cmd),
    .cq_empty (cq_empty),
    .cq_pop   (cq_pop),
    .oq_full  (oq_full),
    .oq_wr    (oq_wr)
  );

  shbe_fifo #(
    .W     (8),
    .DEPTH (OQ_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_wr.push),
    .wr_data (oq_wr.data),
    .full    (oq_full),
    .rd_en   (pop),
    .rd_data (out_byte),
    .empty   (empty)
  );

`ifndef SYNTHESIS
  a_oq_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    oq_wr.push |-> !oq_full)
    else $error("squeeze result written to a full output queue");

  a_cq_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> !cq_empty)
    else $error("back end consumed from an empty command queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");
`endif

endmodule

`default_nettype wire

/* tb/tb_sponge_hash_byte_engine.sv */
`timescale 1ns / 1ps

module tb_sponge_hash_byte_engine;

  import shbe_pkg::*;

  localparam int          N_ROUNDS      = DEF_ROUNDS;
  localparam int unsigned RATE          = DEF_RATE_BYTES;
  localparam int          RANDOM_CMDS   = 1650;
  localparam int          RX_HOLD_CYCLES = 1500;
  localparam int          DRAIN_CYCLES  = 2500;
  localparam int          STALL_LIMIT   = 20000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [1:0] in_kind;
  logic [7:0] in_data_byte;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;

  // predictor state
  logic [63:0] sponge_st [16];
  int unsigned rate_pos;
  bit          in_squeeze;

  logic [7:0] hash_byte_q [$];

  int unsigned mismatch_cnt  = 0;
  int unsigned bytes_checked = 0;
  int unsigned live_cmds     = 0;
  int unsigned ignored_cnt   = 0;
  int unsigned perm_cnt      = 0;
  int unsigned kind_cnt [4]  = '{0, 0, 0, 0};
  int unsigned stall_cycles  = 0;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_go = 1'b0;
  bit rx_hold;

  sponge_hash_byte_engine u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] rot_left(logic [63:0] v, int unsigned n);
    int unsigned amt;
    amt = n % 64;
    if (amt == 0) return v;
    return (v << amt) | (v >> (64 - amt));
  endfunction

  function automatic void permute_sponge();
    logic [63:0] a;
    logic [63:0] b;
    for (int unsigned r = 0; r < N_ROUNDS; r++) begin
      for (int unsigned i = 0; i < 16; i++) begin
        a = rot_left(sponge_st[(r + i) % 16], r + (i >> 1) + 1);
        b = rot_left(sponge_st[(r + i + 1) % 16], r + 2 * i + 1);
        sponge_st[15 - i] ^= a ^ b ^ 64'd1;
      end
    end
    perm_cnt++;
  endfunction

  function automatic void xor_into_rate(int unsigned pos, logic [7:0] v);
    sponge_st[(pos >> 3) % 16] ^= {56'd0, v} << ((pos % 8) * 8);
  endfunction

  function automatic logic [7:0] rate_byte(int unsigned pos);
    logic [63:0] lane;
    lane = sponge_st[(pos >> 3) % 16] >> ((pos % 8) * 8);
    return lane[7:0];
  endfunction

  function automatic void refill_rate();
    if (rate_pos >= RATE) begin
      permute_sponge();
      rate_pos = 0;
    end
  endfunction

  function automatic void clear_sponge();
    foreach (sponge_st[k]) sponge_st[k] = '0;
    rate_pos   = 0;
    in_squeeze = 1'b0;
  endfunction

  function automatic void predict_cmd(logic [1:0] kind, logic [7:0] data);
    kind_cnt[kind]++;
    if (in_squeeze && (kind == KIND_ABSORB || kind == KIND_FINISH)) begin
      ignored_cnt++;
      return;
    end
    live_cmds++;
    case (kind)
      KIND_CLEAR: clear_sponge();
      KIND_ABSORB: begin
        refill_rate();
        xor_into_rate(rate_pos, data);
        rate_pos++;
        refill_rate();
      end
      KIND_FINISH: begin
        refill_rate();
        xor_into_rate(rate_pos, PAD_START);
        xor_into_rate(RATE - 1, PAD_END);
        rate_pos   = RATE;
        in_squeeze = 1'b1;
      end
      default: begin
        refill_rate();
        hash_byte_q.push_back(rate_byte(rate_pos));
        rate_pos++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- input side

  task automatic send_cmd(logic [1:0] kind, logic [7:0] data);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= data;
    do @(posedge clk); while (full);
    predict_cmd(kind, data);
  endtask

  task automatic send_rand(logic [1:0] kind);
    send_cmd(kind, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------- result side

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s got 0x%02h exp 0x%02h", $realtime, what, got, exp);
  endtask

  task automatic check_hash_byte(logic [7:0] got);
    logic [7:0] exp;
    if (hash_byte_q.size() == 0) begin
      report_mismatch("unexpected out_byte", got, 8'h00);
    end else begin
      exp = hash_byte_q.pop_front();
      bytes_checked++;
      if (got !== exp) report_mismatch("out_byte", got, exp);
    end
  endtask

  initial begin : rx_side
    int unsigned wait_left;
    wait_left = 0;
    pop <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        check_hash_byte(out_byte);
        wait_left = rx_idle ? $urandom_range(0, 3) : 0;
      end else if (wait_left > 0) begin
        wait_left--;
      end
      pop <= (wait_left == 0) && !rx_hold;
    end
  end

  initial begin : rx_hold_ctl
    rx_hold <= 1'b0;
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // transfer watchdog
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, stall_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_commands();
    send_cmd(KIND_CLEAR, 8'hFF);
    send_cmd(KIND_ABSORB, 8'h00);
    send_cmd(KIND_ABSORB, 8'hFF);
    send_cmd(KIND_FINISH, 8'hFF);
    repeat (3) send_cmd(KIND_SQUEEZE, 8'h00);
    // absorb and finish are dropped while squeezing
    send_cmd(KIND_ABSORB, 8'hA5);
    send_cmd(KIND_FINISH, 8'h5A);
    send_cmd(KIND_SQUEEZE, 8'hFF);
    send_cmd(KIND_CLEAR, 8'h00);
    // squeeze in absorbing mode keeps the mode
    send_cmd(KIND_SQUEEZE, 8'h00);
    send_cmd(KIND_SQUEEZE, 8'h00);
    send_cmd(KIND_ABSORB, 8'h3C);
    send_cmd(KIND_FINISH, 8'h00);
    send_cmd(KIND_SQUEEZE, 8'h00);
    send_cmd(KIND_SQUEEZE, 8'h00);
  endtask

  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    send_rand(KIND_CLEAR);
    repeat (5) send_rand(KIND_ABSORB);
    send_rand(KIND_FINISH);
    hold_go = 1'b1;
    repeat (30) send_rand(KIND_SQUEEZE);
    tx_idle = 1'b1;
  endtask

  task automatic run_message(int unsigned len, int unsigned n_out, bit with_clear);
    if (with_clear) send_rand(KIND_CLEAR);
    repeat (len) send_rand(KIND_ABSORB);
    send_rand(KIND_FINISH);
    repeat (n_out) begin
      if ($urandom_range(0, 9) == 0) send_rand($urandom_range(0, 1) ? KIND_ABSORB : KIND_FINISH);
      send_rand(KIND_SQUEEZE);
    end
  endtask

  task automatic run_raw_squeezes(int unsigned pre, int unsigned n, logic [1:0] tail);
    send_rand(KIND_CLEAR);
    repeat (pre) send_rand(KIND_ABSORB);
    repeat (n) send_rand(KIND_SQUEEZE);
    send_rand(tail);
    if (tail == KIND_FINISH) repeat ($urandom_range(1, 4)) send_rand(KIND_SQUEEZE);
  endtask

  task automatic test_random_traffic();
    int unsigned iter;
    int unsigned pick;
    int unsigned len;
    int unsigned edge_lens [5] = '{31, 32, 33, 63, 64};
    iter = 0;
    while (live_cmds < RANDOM_CMDS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle <= ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (iter == 0) begin
        // padding bytes land on the same rate byte
        run_message(31, 4, 1'b1);
      end else if (iter == 1) begin
        run_raw_squeezes(0, RATE, KIND_ABSORB);
      end else if (iter == 2) begin
        run_raw_squeezes(3, RATE - 3, KIND_FINISH);
      end else if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? edge_lens[$urandom_range(0, 4)]
                                          : $urandom_range(0, 40);
        run_message(len, $urandom_range(1, 40), $urandom_range(0, 4) != 0);
      end else if (pick < 85) begin
        len = $urandom_range(0, 8);
        run_raw_squeezes(len, $urandom_range(1, 40), $urandom_range(0, 1) ? KIND_ABSORB
                                                                          : KIND_FINISH);
      end else begin
        repeat ($urandom_range(1, 6)) send_rand(2'($urandom_range(0, 3)));
      end
      iter++;
    end
  endtask

  initial begin : main
    rst_n        <= 1'b0;
    push         <= 1'b0;
    in_kind      <= KIND_CLEAR;
    in_data_byte <= 8'h00;
    clear_sponge();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_commands();
    test_output_backpressure();
    test_random_traffic();

    push <= 1'b0;
    while (hash_byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands: %0d clear, %0d absorb, %0d finish, %0d squeeze, %0d dropped",
             kind_cnt.sum(), kind_cnt[KIND_CLEAR],
             kind_cnt[KIND_ABSORB], kind_cnt[KIND_FINISH], kind_cnt[KIND_SQUEEZE], ignored_cnt);
    $display("Checked %0d hash bytes over %0d permutations, %0d mismatches",
             bytes_checked, perm_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
